@@ hw/rtl/sedu_pkg.sv @@
// ----------------------------------------------------------------------------
// sedu_pkg
// Shared types and constants of the sample envelope stream decoder.
// ----------------------------------------------------------------------------
package sedu_pkg;

  localparam int unsigned CODE_TABLE_ENTRIES = 8;
  localparam int unsigned MAX_TABLE_ENTRIES  = 8;
  localparam int unsigned CFG_DATA_W         = 64;
  localparam int unsigned CFG_INDEX_W        = 2;

  localparam logic [7:0]  BYTE_LOOP_MARK = 8'hfe;
  localparam logic [7:0]  BYTE_END_MARK  = 8'hfc;
  localparam logic [15:0] LINE_MAX       = 16'hffff;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_VOLUME_MARKER   = 2'd0,
    CFG_CODE_TABLE_LOW  = 2'd1,
    CFG_CODE_TABLE_HIGH = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_TONE   = 3'd0,
    PH_DEV    = 3'd1,
    PH_VOL    = 3'd2,
    PH_VCOUNT = 3'd3,
    PH_VLEVEL = 3'd4,
    PH_DONE   = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_sample;
  } in_item_t;

  typedef struct packed {
    logic        is_end;
    logic [7:0]  run_length;
    logic [15:0] first_line;
    logic        tone_enabled;
    logic        noise_enabled;
    logic [1:0]  noise_freq;
    logic [10:0] tone_deviation;
    logic [3:0]  left_level;
    logic [3:0]  right_level;
    logic [15:0] total_lines;
    logic [15:0] loop_line;
  } out_item_t;

  typedef struct packed {
    logic [7:0]            volume_marker;
    logic [CFG_DATA_W-1:0] code_table_low;
    logic [CFG_DATA_W-1:0] code_table_high;
  } cfg_t;

endpackage

@@ hw/rtl/sample_envelope_stream_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// sample_envelope_stream_decoder_unit
// Byte-wise decoder of a run-length coded sample envelope stream.
// ----------------------------------------------------------------------------
// Structure: an accepted byte is held in the input register and decoded from
// there; its result is written to the output register.
// Throughput: one byte per cycle unless the output stalls; the path is set by
// the table compare and the 16-bit saturating line add between the two registers.
// Reset: asynchronous, clears parser state, handshake state and config registers.
// ----------------------------------------------------------------------------
module sample_envelope_stream_decoder_unit #(
  parameter int unsigned CodeTableEntries = sedu_pkg::CODE_TABLE_ENTRIES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  sedu_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output sedu_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sedu_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [sedu_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import sedu_pkg::*;

  cfg_t      cfg_q;
  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_item_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;

  logic      out_free, advance, accept;
  logic      res_valid;
  out_item_t res;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign advance     = s1_valid_q && out_free;
  assign in_stall_o  = s1_valid_q && !out_free;
  assign accept      = in_valid_i && !in_stall_o;

  assign s1_valid_d  = accept || (s1_valid_q && !advance);
  assign out_valid_d = advance ? res_valid : (out_valid_q && out_stall_i);

  sedu_parser #(
    .CodeTableEntries(CodeTableEntries)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .item_i     (s1_item_q),
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_VOLUME_MARKER:   cfg_q.volume_marker   <= cfg_data_i[7:0];
        CFG_CODE_TABLE_LOW:  cfg_q.code_table_low  <= cfg_data_i;
        CFG_CODE_TABLE_HIGH: cfg_q.code_table_high <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_item_i;
    end
    if (advance && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_accept_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted byte not held in input register");

  a_taken_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_stall_i && !advance |=> !out_valid_q)
    else $error("delivered result repeated");

  a_stall_blocks_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && s1_valid_q |=> s1_valid_q && $stable(s1_item_q))
    else $error("byte lost while output stalled");

endmodule

@@ hw/rtl/sedu_code_match.sv @@
// ----------------------------------------------------------------------------
// sedu_code_match
// Looks up a volume code in the configured code-to-length table.
// ----------------------------------------------------------------------------
module sedu_code_match #(
  parameter int unsigned CodeTableEntries = sedu_pkg::CODE_TABLE_ENTRIES
) (
  input  sedu_pkg::cfg_t cfg_i,
  input  logic [7:0]     code_i,
  output logic [7:0]     length_o
);
  import sedu_pkg::*;

  logic [2*CFG_DATA_W-1:0] table_words;

  assign table_words = {cfg_i.code_table_high, cfg_i.code_table_low};

  // scan backwards so the first matching entry wins
  always_comb begin
    length_o = 8'd0;
    for (int i = CodeTableEntries - 1; i >= 0; i--) begin
      if (table_words[16*i+8 +: 8] != 8'd0 && table_words[16*i+8 +: 8] == code_i) begin
        length_o = table_words[16*i +: 8];
      end
    end
  end

endmodule

@@ hw/rtl/sedu_parser.sv @@
// ----------------------------------------------------------------------------
// sedu_parser
// Parser state and per-byte decode; forms at most one run or end result per byte.
// ----------------------------------------------------------------------------
module sedu_parser #(
  parameter int unsigned CodeTableEntries = sedu_pkg::CODE_TABLE_ENTRIES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  sedu_pkg::in_item_t  item_i,
  input  sedu_pkg::cfg_t      cfg_i,
  output logic                res_valid_o,
  output sedu_pkg::out_item_t res_o
);
  import sedu_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  tone_left_q, tone_left_d;
  logic [7:0]  vol_left_q, vol_left_d;
  logic        tone_on_q, tone_on_d;
  logic        noise_on_q, noise_on_d;
  logic [1:0]  noise_sel_q, noise_sel_d;
  logic [10:0] dev_q, dev_d;
  logic [7:0]  levels_q, levels_d;
  logic [15:0] lines_q, lines_d;
  logic [15:0] loop_idx_q, loop_idx_d;
  logic        loop_seen_q, loop_seen_d;

  phase_e      cur_phase;
  logic [7:0]  cur_tone, cur_vol;
  logic        cur_tone_on, cur_noise_on;
  logic [1:0]  cur_noise_sel;
  logic [10:0] cur_dev;
  logic [7:0]  cur_levels;
  logic [15:0] cur_lines, cur_loop_idx;
  logic        cur_loop_seen;

  logic [7:0]  b;
  logic [7:0]  code_len;
  logic        is_marker;
  logic [7:0]  tone_pre, vol_pre;
  logic        settle_req, end_req;
  logic [7:0]  run;
  logic        run_emit;
  logic [16:0] line_sum;
  logic [7:0]  tone_post;

  assign b = item_i.data_byte;

  sedu_code_match #(
    .CodeTableEntries(CodeTableEntries)
  ) u_code_match (
    .cfg_i   (cfg_i),
    .code_i  (b),
    .length_o(code_len)
  );

  assign is_marker = (b == cfg_i.volume_marker);

  always_comb begin
    if (item_i.first_of_sample) begin
      cur_phase     = PH_TONE;
      cur_tone      = 8'd0;
      cur_vol       = 8'd0;
      cur_tone_on   = 1'b0;
      cur_noise_on  = 1'b0;
      cur_noise_sel = 2'd0;
      cur_dev       = 11'd0;
      cur_levels    = 8'd0;
      cur_lines     = 16'd0;
      cur_loop_idx  = 16'd0;
      cur_loop_seen = 1'b0;
    end else begin
      cur_phase     = phase_q;
      cur_tone      = tone_left_q;
      cur_vol       = vol_left_q;
      cur_tone_on   = tone_on_q;
      cur_noise_on  = noise_on_q;
      cur_noise_sel = noise_sel_q;
      cur_dev       = dev_q;
      cur_levels    = levels_q;
      cur_lines     = lines_q;
      cur_loop_idx  = loop_idx_q;
      cur_loop_seen = loop_seen_q;
    end
  end

  // decode one byte into updated fields, before the run is taken out
  always_comb begin
    tone_pre    = cur_tone;
    vol_pre     = cur_vol;
    tone_on_d   = cur_tone_on;
    noise_on_d  = cur_noise_on;
    noise_sel_d = cur_noise_sel;
    dev_d       = cur_dev;
    levels_d    = cur_levels;
    loop_idx_d  = cur_loop_idx;
    loop_seen_d = cur_loop_seen;
    settle_req  = 1'b0;
    end_req     = 1'b0;
    case (cur_phase)
      PH_TONE: begin
        if (!b[0]) begin
          if (b == BYTE_LOOP_MARK) begin
            loop_idx_d  = cur_lines;
            loop_seen_d = 1'b1;
          end else if (b == BYTE_END_MARK) begin
            end_req = 1'b1;
          end else begin
            tone_pre = 8'd2 + {1'b0, b[7:1]};
          end
        end else begin
          tone_on_d   = b[4];
          noise_on_d  = b[5];
          noise_sel_d = b[7:6];
          dev_d       = {b[3:1], 8'd0};
        end
      end
      PH_DEV: begin
        dev_d = {cur_dev[10:8], b};
        if (cur_tone == 8'd0) begin
          tone_pre = 8'd1;
        end
        settle_req = (cur_vol != 8'd0);
      end
      PH_VOL: begin
        if (!is_marker && code_len != 8'd0) begin
          vol_pre = code_len;
        end else if (!is_marker) begin
          levels_d   = b;
          vol_pre    = 8'd1;
          settle_req = 1'b1;
        end
      end
      PH_VCOUNT: begin
        vol_pre = b;
      end
      PH_VLEVEL: begin
        levels_d   = b;
        settle_req = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign run       = (tone_pre < vol_pre) ? tone_pre : vol_pre;
  assign run_emit  = settle_req && (run != 8'd0);
  assign line_sum  = {1'b0, cur_lines} + {9'd0, run};
  assign tone_post = settle_req ? tone_pre - run : tone_pre;

  assign tone_left_d = tone_post;
  assign vol_left_d  = settle_req ? vol_pre - run : vol_pre;
  assign lines_d     = !run_emit ? cur_lines :
                       (line_sum[16] ? LINE_MAX : line_sum[15:0]);

  always_comb begin
    phase_d = cur_phase;
    if (settle_req) begin
      phase_d = (tone_post == 8'd0) ? PH_TONE : PH_VOL;
    end else begin
      case (cur_phase)
        PH_TONE: begin
          if (b[0]) begin
            phase_d = PH_DEV;
          end else if (b == BYTE_END_MARK) begin
            phase_d = PH_DONE;
          end
        end
        PH_DEV:    phase_d = PH_VOL;
        PH_VOL: begin
          if (is_marker) begin
            phase_d = PH_VCOUNT;
          end else if (code_len != 8'd0) begin
            phase_d = PH_VLEVEL;
          end
        end
        PH_VCOUNT: phase_d = PH_VLEVEL;
        default:   phase_d = cur_phase;
      endcase
    end
  end

  always_comb begin
    res_valid_o = run_emit || end_req;
    res_o       = '0;
    if (end_req) begin
      res_o.is_end      = 1'b1;
      res_o.total_lines = cur_lines;
      res_o.loop_line   = (cur_loop_seen && cur_loop_idx < cur_lines) ? cur_loop_idx
                                                                      : cur_lines;
    end else begin
      res_o.run_length     = run;
      res_o.first_line     = cur_lines;
      res_o.tone_enabled   = tone_on_d;
      res_o.noise_enabled  = noise_on_d;
      res_o.noise_freq     = noise_sel_d;
      res_o.tone_deviation = dev_d;
      res_o.left_level     = levels_d[3:0];
      res_o.right_level    = levels_d[7:4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TONE;
      tone_left_q <= 8'd0;
      vol_left_q  <= 8'd0;
      tone_on_q   <= 1'b0;
      noise_on_q  <= 1'b0;
      noise_sel_q <= 2'd0;
      dev_q       <= 11'd0;
      levels_q    <= 8'd0;
      lines_q     <= 16'd0;
      loop_idx_q  <= 16'd0;
      loop_seen_q <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      tone_left_q <= tone_left_d;
      vol_left_q  <= vol_left_d;
      tone_on_q   <= tone_on_d;
      noise_on_q  <= noise_on_d;
      noise_sel_q <= noise_sel_d;
      dev_q       <= dev_d;
      levels_q    <= levels_d;
      lines_q     <= lines_d;
      loop_idx_q  <= loop_idx_d;
      loop_seen_q <= loop_seen_d;
    end
  end

  a_lines_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !item_i.first_of_sample |=> lines_q >= $past(lines_q))
    else $error("line count went backwards");

  a_end_enters_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && res_o.is_end |=> phase_q == PH_DONE)
    else $error("end result without done phase");

  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.is_end |-> res_o.run_length != 8'd0)
    else $error("empty run emitted");

endmodule

@@ tb/tb_sample_envelope_stream_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// tb_sample_envelope_stream_decoder_unit
// Self-checking bench for the sample envelope stream decoder. Directed and
// random sample byte streams go through the block, most under random idle and
// stall bursts. A local decoder predicts every run word and end-of-sample
// word, and each received word is compared field by field.
// ----------------------------------------------------------------------------
module tb_sample_envelope_stream_decoder_unit;
  import sedu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic                   clk = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_item = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_item;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  cfg_reg_e               cfg_index = CFG_VOLUME_MARKER;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // decoder model: configuration
  logic [7:0]             esc_byte = 8'h00;
  logic [63:0]            codes_lo = '0;
  logic [63:0]            codes_hi = '0;

  // decoder model: parser state
  phase_e                 stage = PH_TONE;
  logic [7:0]             tone_rem = 8'h00;
  logic [7:0]             vol_rem = 8'h00;
  logic                   tone_bit = 1'b0;
  logic                   noise_bit = 1'b0;
  logic [1:0]             noise_sel = 2'b00;
  logic [10:0]            dev_word = '0;
  logic [7:0]             level_pair = 8'h00;
  logic [15:0]            line_count = '0;
  logic [15:0]            loop_mark_line = '0;
  logic                   loop_marked = 1'b0;

  in_item_t               stream_bytes[$];
  out_item_t              decoded_words[$];
  int                     word_errors = 0;
  int                     idle_pct = 0;
  int                     send_gap = 0;
  int                     recv_gap = 0;
  int                     batch_items = 0;
  logic                   sample_open = 1'b0;

  sample_envelope_stream_decoder_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] code_length(logic [7:0] code);
    logic [15:0] pair;
    for (int i = 0; i < CODE_TABLE_ENTRIES; i++) begin
      pair = (i < 4) ? codes_lo[16*(i%4) +: 16] : codes_hi[16*(i%4) +: 16];
      if (pair[15:8] != 8'h00 && pair[15:8] == code) return pair[7:0];
    end
    return 8'h00;
  endfunction

  task automatic emit_run();
    logic [7:0]  run;
    logic [16:0] sum;
    out_item_t   w;
    run = (tone_rem < vol_rem) ? tone_rem : vol_rem;
    if (run != 8'h00) begin
      w = '0;
      w.run_length     = run;
      w.first_line     = line_count;
      w.tone_enabled   = tone_bit;
      w.noise_enabled  = noise_bit;
      w.noise_freq     = noise_sel;
      w.tone_deviation = dev_word;
      w.left_level     = level_pair[3:0];
      w.right_level    = level_pair[7:4];
      sum = {1'b0, line_count} + 17'(run);
      line_count = sum[16] ? LINE_MAX : sum[15:0];
      tone_rem = tone_rem - run;
      vol_rem  = vol_rem - run;
      decoded_words = {decoded_words, w};
    end
    stage = (tone_rem == 8'h00) ? PH_TONE : PH_VOL;
  endtask

  task automatic decode_byte(in_item_t it);
    logic [7:0] b;
    logic [7:0] len;
    out_item_t  w;
    b = it.data_byte;
    if (it.first_of_sample) begin
      stage = PH_TONE;
      tone_rem = '0;
      vol_rem = '0;
      tone_bit = 1'b0;
      noise_bit = 1'b0;
      noise_sel = '0;
      dev_word = '0;
      level_pair = '0;
      line_count = '0;
      loop_mark_line = '0;
      loop_marked = 1'b0;
    end
    case (stage)
      PH_TONE: begin
        if (!b[0]) begin
          if (b == BYTE_LOOP_MARK) begin
            loop_mark_line = line_count;
            loop_marked = 1'b1;
          end else if (b == BYTE_END_MARK) begin
            w = '0;
            w.is_end = 1'b1;
            w.total_lines = line_count;
            w.loop_line = (loop_marked && loop_mark_line < line_count) ? loop_mark_line
                                                                        : line_count;
            decoded_words = {decoded_words, w};
            stage = PH_DONE;
          end else begin
            tone_rem = 8'd2 + {1'b0, b[7:1]};
          end
        end else begin
          tone_bit = b[4];
          noise_bit = b[5];
          noise_sel = b[7:6];
          dev_word = {b[3:1], 8'h00};
          stage = PH_DEV;
        end
      end
      PH_DEV: begin
        dev_word[7:0] = b;
        if (tone_rem == 8'h00) tone_rem = 8'h01;
        if (vol_rem == 8'h00) stage = PH_VOL;
        else emit_run();
      end
      PH_VOL: begin
        len = code_length(b);
        if (b == esc_byte) begin
          stage = PH_VCOUNT;
        end else if (len != 8'h00) begin
          vol_rem = len;
          stage = PH_VLEVEL;
        end else begin
          level_pair = b;
          vol_rem = 8'h01;
          emit_run();
        end
      end
      PH_VCOUNT: begin
        vol_rem = b;
        stage = PH_VLEVEL;
      end
      PH_VLEVEL: begin
        level_pair = b;
        emit_run();
      end
      default: ;
    endcase
  endtask

  function automatic string word_text(out_item_t w);
    return $sformatf({"end=%0d run=%0d first=%0d tone=%0d noise=%0d nf=%0d dev=%0d",
                      " lvl=%0d/%0d tot=%0d loop=%0d"},
                     w.is_end, w.run_length, w.first_line, w.tone_enabled, w.noise_enabled,
                     w.noise_freq, w.tone_deviation, w.left_level, w.right_level,
                     w.total_lines, w.loop_line);
  endfunction

  always @(posedge clk) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) decode_byte(in_item);
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          send_gap = $urandom_range(0, 18);
          in_valid <= 1'b0;
        end else if (stream_bytes.size() != 0) begin
          in_item <= stream_bytes.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    int        bad;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (decoded_words.size() == 0) begin
          word_errors++;
          if (word_errors <= 10) $display("unexpected word: %s", word_text(out_item));
        end else begin
          want = decoded_words.pop_front();
          bad = (out_item.is_end !== want.is_end) + (out_item.run_length !== want.run_length)
              + (out_item.first_line !== want.first_line)
              + (out_item.tone_enabled !== want.tone_enabled)
              + (out_item.noise_enabled !== want.noise_enabled)
              + (out_item.noise_freq !== want.noise_freq)
              + (out_item.tone_deviation !== want.tone_deviation)
              + (out_item.left_level !== want.left_level)
              + (out_item.right_level !== want.right_level)
              + (out_item.total_lines !== want.total_lines)
              + (out_item.loop_line !== want.loop_line);
          if (bad != 0) begin
            word_errors++;
            if (word_errors <= 10) begin
              $display("word mismatch, expected: %s", word_text(want));
              $display("               actual:   %s", word_text(out_item));
            end
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        recv_gap = $urandom_range(0, 18);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [63:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_VOLUME_MARKER:   esc_byte = v[7:0];
      CFG_CODE_TABLE_LOW:  codes_lo = v;
      CFG_CODE_TABLE_HIGH: codes_hi = v;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [7:0] marker, logic [63:0] lo, logic [63:0] hi, int pct);
    write_reg(CFG_VOLUME_MARKER, {56'h0, marker});
    write_reg(CFG_CODE_TABLE_LOW, lo);
    write_reg(CFG_CODE_TABLE_HIGH, hi);
    idle_pct <= pct;
    @(negedge clk);
  endtask

  function automatic logic [63:0] random_codes(logic [7:0] marker);
    logic [63:0] v;
    logic [7:0]  code;
    logic [7:0]  len;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 3))
        0:       code = 8'h00;
        1:       code = marker;
        default: code = 8'($urandom_range(1, 255));
      endcase
      len = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 6)) : 8'($urandom);
      v[16*i +: 16] = {code, len};
    end
    return v;
  endfunction

  task automatic push_byte(logic [7:0] b);
    in_item_t it;
    it.data_byte = b;
    it.first_of_sample = sample_open;
    sample_open = 1'b0;
    stream_bytes = {stream_bytes, it};
    batch_items++;
  endtask

  task automatic push_seq(logic [255:0] seq, int n);
    sample_open = 1'b1;
    for (int i = 0; i < n; i++) push_byte(seq[8*(n-1-i) +: 8]);
  endtask

  // track both run counters so every part comes where the parser wants it
  task automatic gen_sample(int runs, bit long_lines, bit with_end);
    int          tone_n;
    int          vol_n;
    int          done_runs;
    int          lines_n;
    int          step;
    int          n_pre;
    logic [7:0]  b;
    logic [7:0]  cnt;
    logic [63:0] word;
    in_item_t    junk;
    tone_n = 0;
    vol_n = 0;
    done_runs = 0;
    lines_n = 0;
    sample_open = 1'b1;
    while (long_lines ? lines_n < 66000 : done_runs < runs) begin
      if (tone_n == 0) begin
        if (long_lines) n_pre = 1;
        else if ($urandom_range(0, 9) < 5) n_pre = 0;
        else n_pre = ($urandom_range(0, 9) < 7) ? 1 : 2;
        for (int k = 0; k < n_pre; k++) begin
          if ($urandom_range(0, 99) < (long_lines ? 1 : 15)) begin
            push_byte(BYTE_LOOP_MARK);
          end else begin
            if (long_lines) b = 8'hfa;
            else if ($urandom_range(0, 1) != 0) b = 8'(2 * $urandom_range(0, 8));
            else b = 8'(2 * $urandom_range(0, 125));
            push_byte(b);
            tone_n = 2 + b[7:1];
          end
        end
        if (tone_n == 0) tone_n = 1;
        push_byte({7'($urandom), 1'b1});
        push_byte(8'($urandom));
      end
      while (vol_n == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: b = esc_byte;
          4, 5, 6: begin
            word = ($urandom_range(0, 1) != 0) ? codes_hi : codes_lo;
            b = word[16*$urandom_range(0, 3) + 8 +: 8];
          end
          default: b = 8'($urandom);
        endcase
        if (long_lines) b = esc_byte;
        push_byte(b);
        if (b == esc_byte) begin
          case ($urandom_range(0, 9))
            0:             cnt = 8'h00;
            1, 2, 3, 4, 5: cnt = 8'($urandom_range(1, 6));
            default:       cnt = 8'($urandom);
          endcase
          if (long_lines) cnt = 8'hff;
          push_byte(cnt);
          push_byte(8'($urandom));
          vol_n = cnt;
        end else if (code_length(b) != 8'h00) begin
          vol_n = code_length(b);
          push_byte(8'($urandom));
        end else begin
          vol_n = 1;
        end
      end
      step = (tone_n < vol_n) ? tone_n : vol_n;
      tone_n -= step;
      vol_n -= step;
      lines_n += step;
      done_runs++;
    end
    if (with_end) begin
      if ($urandom_range(0, 3) == 0) push_byte(BYTE_LOOP_MARK);
      push_byte(BYTE_END_MARK);
      repeat ($urandom_range(0, 2)) begin
        junk = {8'($urandom), 1'b0};
        stream_bytes = {stream_bytes, junk};
      end
    end
  endtask

  task automatic run_batch(int target);
    batch_items = 0;
    while (batch_items < target) begin
      case ($urandom_range(0, 9))
        0: begin
          sample_open = 1'b1;
          repeat ($urandom_range(2, 12)) begin
            if ($urandom_range(0, 7) == 0) sample_open = 1'b1;
            push_byte(8'($urandom));
          end
        end
        1:       gen_sample($urandom_range(1, 6), 1'b0, 1'b0);
        default: gen_sample($urandom_range(1, 12), 1'b0, 1'b1);
      endcase
    end
  endtask

  task automatic quiesce();
    @(negedge clk);
    while (stream_bytes.size() != 0 || in_valid || decoded_words.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [7:0] marker;
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;

    set_config(8'h00, 64'h0, 64'h0, 30);
    push_seq({8'hfe, 8'h10, 8'h04, 8'hff, 8'hff, 8'h00, 8'h00, 8'h5a,
              8'hff, 8'h00, 8'hff, 8'ha5, 8'hfe, 8'h01, 8'h00, 8'hfc}, 16);
    push_seq(8'hfc, 1);
    run_batch(300);

    quiesce();
    set_config(8'h80, 64'h8005_4007_4100_4003, 64'h9902_0000_0009_c3ff, 10);
    push_seq({8'h11, 8'h22, 8'h40, 8'h12, 8'h06, 8'hf1, 8'h9a, 8'h41,
              8'h80, 8'h01, 8'h77, 8'h00, 8'hfc}, 13);
    run_batch(300);

    quiesce();
    set_config(8'hff, {64{1'b1}}, {64{1'b1}}, 0);
    run_batch(200);

    quiesce();
    marker = 8'($urandom);
    set_config(marker, random_codes(marker), random_codes(marker), $urandom_range(5, 50));
    run_batch(200);

    // hold off idling for the last part of the run
    quiesce();
    marker = 8'($urandom);
    set_config(marker, random_codes(marker), random_codes(marker), 0);
    run_batch(200);

    quiesce();
    repeat (4) @(posedge clk);
    if (word_errors == 0) begin
      $display("sample_envelope_stream_decoder_unit verification clean");
    end else begin
      $display("sample_envelope_stream_decoder_unit verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("sample_envelope_stream_decoder_unit verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/sedu_pkg.sv
hw/rtl/sedu_code_match.sv
hw/rtl/sedu_parser.sv
hw/rtl/sample_envelope_stream_decoder_unit.sv
tb/tb_sample_envelope_stream_decoder_unit.sv
